[rtl/core/can_bts_pkg.sv]
// Shared types and constants for the CAN bit timing solver
package can_bts_pkg;

	localparam int unsigned CLK_W       = 32;
	localparam int unsigned RATE_W      = 20;
	localparam int unsigned SEG_W       = 5;
	localparam int unsigned WORD_W      = 15;
	localparam int unsigned DIVSEL_W    = 4;
	localparam int unsigned STEP_CNT_W  = 5;

	localparam logic [SEG_W-1:0]  SEGS_MIN       = 5'd3;
	localparam logic [SEG_W-1:0]  SEGS_MAX       = 5'd17;
	localparam logic [RATE_W-1:0] BIT_RATE_RESET = 20'd500000;
	localparam logic [2:0]        SJW_MAX        = 3'd3;

	typedef struct packed {
		logic [CLK_W-1:0] main_clock_hz;
	} in_t;

	typedef struct packed {
		logic [RATE_W-1:0] bit_rate;
	} cfg_t;

	typedef struct packed {
		logic                found;
		logic [DIVSEL_W-1:0] clock_divider;
		logic [WORD_W-1:0]   bit_timing_word;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SEARCH,
		ST_OUT
	} state_t;

endpackage

[rtl/core/can_bts_chan_if.sv]
// Valid/ready channel carrying one payload
interface can_bts_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/can_bts_div.sv]
// Restoring divider, one quotient bit per cycle, clocks per bit
module can_bts_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [can_bts_pkg::CLK_W-1:0]       dividend,
	input  logic [can_bts_pkg::RATE_W-1:0]      divisor,
	output logic                                done,
	output logic [can_bts_pkg::CLK_W-1:0]       quotient
);
	logic                                 busy_q;
	logic                                 done_q;
	logic [can_bts_pkg::STEP_CNT_W-1:0]   cnt_q;
	logic [can_bts_pkg::RATE_W-1:0]       rem_q;
	logic [can_bts_pkg::RATE_W-1:0]       divisor_q;
	logic [can_bts_pkg::CLK_W-1:0]        quo_q;
	logic [can_bts_pkg::RATE_W:0]         trial;
	logic [can_bts_pkg::RATE_W:0]         diff;
	logic                                 qbit;

	assign trial = {rem_q, quo_q[can_bts_pkg::CLK_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign qbit  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[can_bts_pkg::RATE_W-1:0] : trial[can_bts_pkg::RATE_W-1:0];
			quo_q <= {quo_q[can_bts_pkg::CLK_W-2:0], qbit};
		end
	end

	// a zero bit rate gives zero clocks per bit
	assign done     = done_q;
	assign quotient = (divisor_q == '0) ? '0 : quo_q;
endmodule

[rtl/core/can_bts_search.sv]
// Divider / quanta / segment search, one trial product per cycle
module can_bts_search #(
	parameter int unsigned DIVIDER_MAX = 15,
	parameter int unsigned QUANTA_MAX  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [can_bts_pkg::CLK_W-1:0] per_bit,
	output logic                          done,
	output can_bts_pkg::out_t             res
);
	localparam int unsigned DW = (DIVIDER_MAX > 0) ? $clog2(DIVIDER_MAX + 1) : 1;
	localparam int unsigned QW = $clog2(QUANTA_MAX + 1);
	localparam int unsigned PW = $clog2(QUANTA_MAX * (DIVIDER_MAX + 1) + 1);
	localparam int unsigned MW = can_bts_pkg::SEG_W + PW;

	logic                              busy_q;
	logic                              done_q;
	logic [DW-1:0]                     d_q;
	logic [QW-1:0]                     q_q;
	logic [can_bts_pkg::SEG_W-1:0]     s_q;
	logic [PW-1:0]                     qd_q;
	logic [can_bts_pkg::CLK_W-1:0]     per_bit_q;
	can_bts_pkg::out_t                 res_q;

	logic [MW-1:0]                     prod;
	logic                              match;
	logic                              s_last;
	logic                              q_last;
	logic                              d_last;
	logic [3:0]                        rest;
	logic [2:0]                        t1;
	logic [2:0]                        t2;
	logic [1:0]                        sjw;
	logic [6:0]                        qm1;

	// s * q * (d + 1), with q * (d + 1) kept in qd_q
	assign prod   = MW'(s_q) * MW'(qd_q);
	assign match  = busy_q && (can_bts_pkg::CLK_W'(prod) == per_bit_q);
	assign s_last = s_q == can_bts_pkg::SEGS_MAX;
	assign q_last = q_q == QW'(QUANTA_MAX);
	assign d_last = d_q == DW'(DIVIDER_MAX);

	assign rest = 4'(s_q - can_bts_pkg::SEGS_MIN);
	assign t1   = rest[3:1];
	assign t2   = 3'(rest - {1'b0, t1});
	assign sjw  = (t1 > can_bts_pkg::SJW_MAX) ? 2'(can_bts_pkg::SJW_MAX) : t1[1:0];
	assign qm1  = 7'(q_q) - 7'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (match || (s_last && q_last && d_last))) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			per_bit_q <= per_bit;
			d_q       <= '0;
			q_q       <= QW'(1);
			s_q       <= can_bts_pkg::SEGS_MIN;
			qd_q      <= PW'(1);
			res_q     <= '0;
		end else if (busy_q) begin
			if (match) begin
				res_q.found           <= 1'b1;
				res_q.clock_divider   <= can_bts_pkg::DIVSEL_W'(d_q);
				res_q.bit_timing_word <= {t2, 1'b0, t1, sjw, qm1[5:0]};
			end else if (s_last) begin
				s_q <= can_bts_pkg::SEGS_MIN;
				if (q_last) begin
					q_q  <= QW'(1);
					d_q  <= d_q + 1'b1;
					qd_q <= PW'(d_q) + PW'(2);
				end else begin
					q_q  <= q_q + 1'b1;
					qd_q <= qd_q + PW'(d_q) + PW'(1);
				end
			end else begin
				s_q <= s_q + 1'b1;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

[rtl/core/can_bit_timing_solver.sv]
// Top level of the CAN bit timing solver
//
//  channel  dir  payload                                      accepted when
//  in_ch    in   main_clock_hz[31:0]                          valid && ready
//  cfg_ch   in   bit_rate[19:0]                               valid && ready
//  out_ch   out  found, clock_divider[3:0], bit_timing_word    valid && ready
//
// One request at a time: bit-serial division, then a hand-over to the search
// unit, then one trial per cycle, up to 15 * QUANTA_MAX * (DIVIDER_MAX + 1)
// trials (7680 at defaults). The next request can be taken once the result is
// offered.
// in_ch.ready is high only while idle; a result that finds the output register
// full waits in the search unit and holds off the input. cfg_ch is always
// ready. Reset sets bit_rate to 500000 and empties the output register.
module can_bit_timing_solver #(
	parameter int unsigned DIVIDER_MAX = 15,
	parameter int unsigned QUANTA_MAX  = 32
) (
	input logic           clk,
	input logic           arst_n,
	can_bts_chan_if.sink   in_ch,
	can_bts_chan_if.sink   cfg_ch,
	can_bts_chan_if.source out_ch
);
	can_bts_pkg::state_t               state_q;
	can_bts_pkg::state_t               state_d;
	logic [can_bts_pkg::RATE_W-1:0]    bit_rate_q;
	logic                              in_acc;
	logic                              div_done;
	logic [can_bts_pkg::CLK_W-1:0]     per_bit;
	logic                              srch_done;
	can_bts_pkg::out_t                 srch_res;
	can_bts_pkg::in_t                  in_req;
	can_bts_pkg::cfg_t                 cfg_req;
	logic                              out_full_q;
	can_bts_pkg::out_t                 out_q;
	logic                              out_load;

	assign in_req  = in_ch.payload;
	assign cfg_req = cfg_ch.payload;

	assign in_ch.ready  = state_q == can_bts_pkg::ST_IDLE;
	assign cfg_ch.ready = 1'b1;
	assign in_acc       = in_ch.valid && in_ch.ready;

	// result moves to the output register once that is free or being emptied
	assign out_load = ((state_q == can_bts_pkg::ST_SEARCH && srch_done)
		|| state_q == can_bts_pkg::ST_OUT) && (!out_full_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_rate_q <= can_bts_pkg::BIT_RATE_RESET;
		end else if (cfg_ch.valid) begin
			bit_rate_q <= cfg_req.bit_rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= can_bts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			can_bts_pkg::ST_IDLE:   if (in_acc) state_d = can_bts_pkg::ST_DIV;
			can_bts_pkg::ST_DIV:    if (div_done) state_d = can_bts_pkg::ST_SEARCH;
			can_bts_pkg::ST_SEARCH: if (srch_done)
				state_d = out_load ? can_bts_pkg::ST_IDLE : can_bts_pkg::ST_OUT;
			can_bts_pkg::ST_OUT:    if (out_load) state_d = can_bts_pkg::ST_IDLE;
			default:                state_d = can_bts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (out_load) begin
			out_full_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= srch_res;
	end

	can_bts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.dividend (in_req.main_clock_hz),
		.divisor  (bit_rate_q),
		.done     (div_done),
		.quotient (per_bit)
	);

	can_bts_search #(
		.DIVIDER_MAX (DIVIDER_MAX),
		.QUANTA_MAX  (QUANTA_MAX)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_done),
		.per_bit (per_bit),
		.done    (srch_done),
		.res     (srch_res)
	);

	assign out_ch.valid   = out_full_q;
	assign out_ch.payload = out_q;
endmodule
